### src/frd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frd_pkg
// Shared widths, register indexes and the side-band record carried down the
// Fresnel reflectance cell chain.
// ----------------------------------------------------------------------------
package frd_pkg;

  localparam int COS_FRAC  = 14;
  localparam int CW        = COS_FRAC + 2;          // cos ports, signed Q1.14
  localparam int CIW       = COS_FRAC + 1;          // |cos|, up to 1.0
  localparam int IDXW      = 15;                    // index regs, Q2.13
  localparam int SQW       = 2 * COS_FRAC + 1;      // 1 - cos^2 in Q28
  localparam int NSQW      = 2 * IDXW;              // index squared
  localparam int RHSW      = SQW + NSQW;            // s * ni^2
  localparam int NUMW      = NSQW + 2 * COS_FRAC;   // nt^2 * 2^28
  localparam int QW        = SQW;                   // cos_t^2 in Q28
  localparam int CTW       = CIW;                   // cos_t in Q14
  localparam int PW        = IDXW + CTW;            // n * cos
  localparam int RBITS     = 16;
  localparam int RDENW     = PW + 1;
  localparam int RREMW     = RDENW + RBITS;
  localparam int RQW       = RBITS + 1;             // ratio up to 1.0 in Q16
  localparam int RSQW      = 2 * RQW;
  localparam int REFW      = 16;
  localparam int REF_SHIFT = 2 * RBITS - 14;

  localparam logic signed [CW-1:0] COS_ONE  = CW'(1 << COS_FRAC);
  localparam logic [SQW-1:0]       ONE_SQ   = SQW'(1) << (2 * COS_FRAC);
  localparam logic [REFW-1:0]      REFL_ONE = REFW'(1 << 15);

  localparam logic REG_OUTER = 1'b0;
  localparam logic REG_INNER = 1'b1;

  typedef struct packed {
    logic                   valid;
    logic                   equal;
    logic                   tir;
    logic                   entering;
    logic signed [CW-1:0]   c_sat;
    logic [CIW-1:0]         ci;
    logic [CTW-1:0]         ct;
    logic [IDXW-1:0]        n1;
    logic [IDXW-1:0]        n2;
  } side_t;

  localparam int SW = $bits(side_t);

endpackage
`default_nettype wire

### src/frd_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frd_div_cell
// One restoring-division cell: resolves quotient bit BIT against the divisor
// shifted left by BIT, then registers remainder, quotient and side band.
// ----------------------------------------------------------------------------
module frd_div_cell #(
  parameter int RW  = 58,
  parameter int DW  = 30,
  parameter int QW  = 29,
  parameter int BIT = 0,
  parameter int SW  = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic [RW-1:0] rem_in,
  input  wire logic [DW-1:0] den_in,
  input  wire logic [QW-1:0] quo_in,
  input  wire logic [SW-1:0] side_in,
  output logic      [RW-1:0] rem_out,
  output logic      [DW-1:0] den_out,
  output logic      [QW-1:0] quo_out,
  output logic      [SW-1:0] side_out
);

  logic [RW:0]   trial;
  logic          ge;
  logic [RW-1:0] rem_next;
  logic [QW-1:0] quo_next;

  always_comb begin
    trial    = (RW+1)'(den_in) << BIT;
    ge       = {1'b0, rem_in} >= trial;
    rem_next = ge ? RW'({1'b0, rem_in} - trial) : rem_in;
    quo_next = ge ? (quo_in | (QW'(1) << BIT)) : quo_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else if (en) begin
      side_out <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      den_out <= den_in;
      quo_out <= quo_next;
    end
  end

endmodule
`default_nettype wire

### src/frd_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frd_sqrt_cell
// One digit of the floor square root: keeps rem = v - res^2 and tries to set
// result bit BIT using only a shifted add and a compare.
// ----------------------------------------------------------------------------
module frd_sqrt_cell #(
  parameter int VW   = 29,
  parameter int RESW = 15,
  parameter int BIT  = 0,
  parameter int SW   = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic [VW-1:0]   rem_in,
  input  wire logic [RESW-1:0] res_in,
  input  wire logic [SW-1:0]   side_in,
  output logic      [VW-1:0]   rem_out,
  output logic      [RESW-1:0] res_out,
  output logic      [SW-1:0]   side_out
);

  localparam int TW = 2 * RESW + 2;

  logic [TW-1:0]   trial;
  logic            ge;
  logic [VW-1:0]   rem_next;
  logic [RESW-1:0] res_next;

  // (res + 2^k)^2 - res^2 = res*2^(k+1) + 2^(2k)
  always_comb begin
    trial    = (TW'(res_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    ge       = TW'(rem_in) >= trial;
    rem_next = ge ? VW'(TW'(rem_in) - trial) : rem_in;
    res_next = ge ? (res_in | (RESW'(1) << BIT)) : res_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else if (en) begin
      side_out <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      res_out <= res_next;
    end
  end

endmodule
`default_nettype wire

### src/fresnel_dielectric_reflectance.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance
// Unpolarized Fresnel reflectance and transmitted cosine at a dielectric
// boundary, built as a chain of division and square-root cells.
// ----------------------------------------------------------------------------
//  channel  signals                               direction
//  in       in_valid/in_ready, cos_incident       into block
//  out      out_valid/out_ready, reflectance,     out of block
//           cos_transmitted, total_internal
//  cfg      cfg_valid/cfg_ready, cfg_index,       into block
//           cfg_data
//
//  One item per cycle while the chain advances; 4 setup stages, 29 divide
//  cells, 15 square-root cells, 2 ratio setup stages, 17 ratio divide cells,
//  square stage and output register.
//  The whole chain advances together; it holds while out_valid is high and
//  out_ready is low, and in_ready follows that.
//  Synchronous reset clears valid flags and sets both indices to 1.0.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [frd_pkg::CW-1:0]   cos_incident,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic        [frd_pkg::REFW-1:0]      reflectance,
  output logic signed [frd_pkg::CW-1:0]        cos_transmitted,
  output logic                                 total_internal,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic                            cfg_index,
  input  wire logic   [frd_pkg::IDXW-1:0]      cfg_data
);

  localparam int SW    = frd_pkg::SW;
  localparam int QW    = frd_pkg::QW;
  localparam int CTW   = frd_pkg::CTW;
  localparam int RQW   = frd_pkg::RQW;
  localparam int NUMW  = frd_pkg::NUMW;
  localparam int NSQW  = frd_pkg::NSQW;
  localparam int SQW   = frd_pkg::SQW;
  localparam int RREMW = frd_pkg::RREMW;
  localparam int RDENW = frd_pkg::RDENW;

  logic adv;
  logic [frd_pkg::IDXW-1:0] outer_index;
  logic [frd_pkg::IDXW-1:0] inner_index;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_index <= frd_pkg::IDXW'(8192);
      inner_index <= frd_pkg::IDXW'(8192);
    end else if (cfg_valid) begin
      case (cfg_index)
        frd_pkg::REG_OUTER: outer_index <= cfg_data;
        frd_pkg::REG_INNER: inner_index <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- stage A: saturate, magnitude, index pick
  frd_pkg::side_t sa, sa_next;

  always_comb begin
    sa_next = '0;
    sa_next.valid = in_valid;
    if (cos_incident > frd_pkg::COS_ONE) begin
      sa_next.c_sat = frd_pkg::COS_ONE;
    end else if (cos_incident < -frd_pkg::COS_ONE) begin
      sa_next.c_sat = -frd_pkg::COS_ONE;
    end else begin
      sa_next.c_sat = cos_incident;
    end
    sa_next.entering = sa_next.c_sat > 0;
    sa_next.ci = sa_next.c_sat[frd_pkg::CW-1] ? frd_pkg::CIW'(-sa_next.c_sat)
                                              : frd_pkg::CIW'(sa_next.c_sat);
    sa_next.n1    = outer_index;
    sa_next.n2    = inner_index;
    sa_next.equal = outer_index == inner_index;
  end

  // ---- stage B: 1 - c^2, squared indices
  frd_pkg::side_t sb;
  logic [SQW-1:0]  sb_s;
  logic [NSQW-1:0] sb_nisq, sb_ntsq;

  // ---- stage C: s * ni^2
  frd_pkg::side_t sc;
  logic [frd_pkg::RHSW-1:0] sc_rhs;
  logic [NSQW-1:0]          sc_ntsq;

  // ---- stage D: numerator and total reflection test
  frd_pkg::side_t sd, sd_next;
  logic [NUMW-1:0]          sd_num;
  logic [NSQW-1:0]          sd_den;
  logic [frd_pkg::RHSW-1:0] lhs_c;

  always_comb begin
    lhs_c       = frd_pkg::RHSW'({sc_ntsq, {(2 * frd_pkg::COS_FRAC){1'b0}}});
    sd_next     = sc;
    sd_next.tir = lhs_c <= sc_rhs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.valid <= 1'b0;
      sb.valid <= 1'b0;
      sc.valid <= 1'b0;
      sd.valid <= 1'b0;
    end else if (adv) begin
      sa.valid <= sa_next.valid;
      sb.valid <= sa.valid;
      sc.valid <= sb.valid;
      sd.valid <= sc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa[SW-2:0] <= sa_next[SW-2:0];
      sb[SW-2:0] <= sa[SW-2:0];
      sb_s       <= frd_pkg::ONE_SQ - SQW'(sa.ci * sa.ci);
      sb_nisq    <= sa.entering ? NSQW'(sa.n1 * sa.n1) : NSQW'(sa.n2 * sa.n2);
      sb_ntsq    <= sa.entering ? NSQW'(sa.n2 * sa.n2) : NSQW'(sa.n1 * sa.n1);
      sc[SW-2:0] <= sb[SW-2:0];
      sc_rhs     <= frd_pkg::RHSW'(sb_s * sb_nisq);
      sc_ntsq    <= sb_ntsq;
      sd[SW-2:0] <= sd_next[SW-2:0];
      sd_num     <= sd_next.tir ? '0 : NUMW'(lhs_c - sc_rhs);
      sd_den     <= sc_ntsq;
    end
  end

  // ---- divide chain: cos_t^2 = num / nt^2
  logic [NUMW-1:0] dv_rem  [0:QW];
  logic [NSQW-1:0] dv_den  [0:QW];
  logic [QW-1:0]   dv_quo  [0:QW];
  logic [SW-1:0]   dv_side [0:QW];

  assign dv_rem[0]  = sd_num;
  assign dv_den[0]  = sd_den;
  assign dv_quo[0]  = '0;
  assign dv_side[0] = sd;

  for (genvar j = 0; j < QW; j++) begin : g_div
    frd_div_cell #(
      .RW(NUMW), .DW(NSQW), .QW(QW), .BIT(QW - 1 - j), .SW(SW)
    ) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .rem_in(dv_rem[j]), .den_in(dv_den[j]), .quo_in(dv_quo[j]),
      .side_in(dv_side[j]),
      .rem_out(dv_rem[j+1]), .den_out(dv_den[j+1]), .quo_out(dv_quo[j+1]),
      .side_out(dv_side[j+1])
    );
  end

  // ---- square-root chain
  logic [QW-1:0]  sq_rem  [0:CTW];
  logic [CTW-1:0] sq_res  [0:CTW];
  logic [SW-1:0]  sq_side [0:CTW];

  assign sq_rem[0]  = dv_quo[QW];
  assign sq_res[0]  = '0;
  assign sq_side[0] = dv_side[QW];

  for (genvar j = 0; j < CTW; j++) begin : g_sqrt
    frd_sqrt_cell #(
      .VW(QW), .RESW(CTW), .BIT(CTW - 1 - j), .SW(SW)
    ) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .rem_in(sq_rem[j]), .res_in(sq_res[j]), .side_in(sq_side[j]),
      .rem_out(sq_rem[j+1]), .res_out(sq_res[j+1]), .side_out(sq_side[j+1])
    );
  end

  // ---- stage E: cross products; stage F: ratio operands
  frd_pkg::side_t se, se_next, sf;
  logic [frd_pkg::PW-1:0] e_a1, e_b1, e_a2, e_b2;
  logic [RREMW-1:0]       f_nums, f_nump;
  logic [RDENW-1:0]       f_dens, f_denp;
  logic [RDENW-1:0]       dsum1, dsum2;
  logic [frd_pkg::PW-1:0] diff1, diff2;

  always_comb begin
    se_next    = sq_side[CTW];
    se_next.ct = sq_res[CTW];
    dsum1      = RDENW'(e_a1) + RDENW'(e_b1);
    dsum2      = RDENW'(e_a2) + RDENW'(e_b2);
    diff1      = (e_a1 > e_b1) ? e_a1 - e_b1 : e_b1 - e_a1;
    diff2      = (e_a2 > e_b2) ? e_a2 - e_b2 : e_b2 - e_a2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      se.valid <= 1'b0;
      sf.valid <= 1'b0;
    end else if (adv) begin
      se.valid <= se_next.valid;
      sf.valid <= se.valid;
    end
  end

  // a zero denominator reads as ratio 1.0: feed 2^16 / 1
  always_ff @(posedge clk) begin
    if (adv) begin
      se[SW-2:0] <= se_next[SW-2:0];
      e_a1       <= frd_pkg::PW'(se_next.n1 * se_next.ci);
      e_b1       <= frd_pkg::PW'(se_next.n2 * se_next.ct);
      e_a2       <= frd_pkg::PW'(se_next.n2 * se_next.ci);
      e_b2       <= frd_pkg::PW'(se_next.n1 * se_next.ct);
      sf[SW-2:0] <= se[SW-2:0];
      f_nums     <= (dsum1 == '0) ? RREMW'(1) << frd_pkg::RBITS
                                  : RREMW'({diff1, {frd_pkg::RBITS{1'b0}}});
      f_dens     <= (dsum1 == '0) ? RDENW'(1) : dsum1;
      f_nump     <= (dsum2 == '0) ? RREMW'(1) << frd_pkg::RBITS
                                  : RREMW'({diff2, {frd_pkg::RBITS{1'b0}}});
      f_denp     <= (dsum2 == '0) ? RDENW'(1) : dsum2;
    end
  end

  // ---- ratio divide chains (s and p run side by side)
  logic [RREMW-1:0] rs_rem [0:RQW], rp_rem [0:RQW];
  logic [RDENW-1:0] rs_den [0:RQW], rp_den [0:RQW];
  logic [RQW-1:0]   rs_quo [0:RQW], rp_quo [0:RQW];
  logic [SW-1:0]    rs_side [0:RQW];
  logic             rp_vld  [0:RQW];

  assign rs_rem[0]  = f_nums;
  assign rs_den[0]  = f_dens;
  assign rs_quo[0]  = '0;
  assign rs_side[0] = sf;
  assign rp_rem[0]  = f_nump;
  assign rp_den[0]  = f_denp;
  assign rp_quo[0]  = '0;
  assign rp_vld[0]  = sf.valid;

  for (genvar j = 0; j < RQW; j++) begin : g_ratio
    frd_div_cell #(
      .RW(RREMW), .DW(RDENW), .QW(RQW), .BIT(RQW - 1 - j), .SW(SW)
    ) u_s (
      .clk(clk), .rst(rst), .en(adv),
      .rem_in(rs_rem[j]), .den_in(rs_den[j]), .quo_in(rs_quo[j]),
      .side_in(rs_side[j]),
      .rem_out(rs_rem[j+1]), .den_out(rs_den[j+1]), .quo_out(rs_quo[j+1]),
      .side_out(rs_side[j+1])
    );
    frd_div_cell #(
      .RW(RREMW), .DW(RDENW), .QW(RQW), .BIT(RQW - 1 - j), .SW(1)
    ) u_p (
      .clk(clk), .rst(rst), .en(adv),
      .rem_in(rp_rem[j]), .den_in(rp_den[j]), .quo_in(rp_quo[j]),
      .side_in(rp_vld[j]),
      .rem_out(rp_rem[j+1]), .den_out(rp_den[j+1]), .quo_out(rp_quo[j+1]),
      .side_out(rp_vld[j+1])
    );
  end

  // ---- stage G: squares; stage H: output register
  frd_pkg::side_t sg, sr;
  logic [frd_pkg::RSQW-1:0] g_rs2, g_rp2;
  logic [frd_pkg::RSQW:0]   sum_c;
  logic [frd_pkg::RSQW-frd_pkg::REF_SHIFT:0] refl_c;
  logic [frd_pkg::REFW-1:0] refl_sat;

  assign sr = rs_side[RQW];

  always_comb begin
    sum_c    = (frd_pkg::RSQW+1)'(g_rs2) + (frd_pkg::RSQW+1)'(g_rp2);
    refl_c   = sum_c[frd_pkg::RSQW:frd_pkg::REF_SHIFT];
    refl_sat = (refl_c > $bits(refl_c)'(frd_pkg::REFL_ONE)) ? frd_pkg::REFL_ONE
                                                           : frd_pkg::REFW'(refl_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sg.valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      sg.valid  <= sr.valid;
      out_valid <= sg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sg[SW-2:0] <= sr[SW-2:0];
      g_rs2      <= frd_pkg::RSQW'(rs_quo[RQW] * rs_quo[RQW]);
      g_rp2      <= frd_pkg::RSQW'(rp_quo[RQW] * rp_quo[RQW]);
      if (sg.equal) begin
        reflectance     <= '0;
        cos_transmitted <= -sg.c_sat;
        total_internal  <= 1'b0;
      end else if (sg.tir) begin
        reflectance     <= frd_pkg::REFL_ONE;
        cos_transmitted <= '0;
        total_internal  <= 1'b1;
      end else begin
        reflectance     <= refl_sat;
        cos_transmitted <= sg.entering ? -$signed(frd_pkg::CW'(sg.ct))
                                       : $signed(frd_pkg::CW'(sg.ct));
        total_internal  <= 1'b0;
      end
    end
  end

  // ---- checks
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    rp_vld[RQW] == sr.valid)
    else $error("s and p ratio lanes out of step");

  a_tir_outputs: assert property (@(posedge clk) disable iff (rst)
    out_valid && total_internal |->
      reflectance == frd_pkg::REFL_ONE && cos_transmitted == '0)
    else $error("total reflection result malformed");

  a_refl_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reflectance <= frd_pkg::REFL_ONE)
    else $error("reflectance above 1.0");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("chain stalled with empty output");

endmodule
`default_nettype wire
